@@ hdl/u8d_pkg.sv @@
package u8d_pkg;

  localparam int unsigned CP_W         = 21;
  localparam int unsigned MAX_RES      = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CP_W-1:0] SUBST_CP = 21'h0025A1;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            rep;
  } result_t;

  // one accepted byte worth of results, oldest in slot 0
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MAX_RES-1:0]       res;
    logic                        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // followers a lead byte takes, 0 if it is no lead
  function automatic logic [1:0] lead_len(input logic [7:0] c);
    logic [1:0] n;
    n = 2'd0;
    if (c[7:5] == 3'b110) n = 2'd1;
    else if (c[7:4] == 4'b1110) n = 2'd2;
    else if (c[7:3] == 5'b11110) n = 2'd3;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

  function automatic result_t subst();
    result_t r;
    r.cp  = SUBST_CP;
    r.rep = 1'b1;
    return r;
  endfunction

  // a lone byte on its own: ascii passes through, anything else is the substitute
  function automatic result_t single(input logic [7:0] c);
    result_t r;
    if (!c[7]) begin
      r.cp  = {{(CP_W-8){1'b0}}, c};
      r.rep = 1'b0;
    end else begin
      r = subst();
    end
    return r;
  endfunction

  // lead plus n followers; the last follower is always fl
  function automatic result_t assemble(input logic [7:0] lead, input logic [7:0] f0,
                                       input logic [7:0] f1, input logic [7:0] fl,
                                       input logic [1:0] n);
    result_t r;
    logic    ok;
    r.rep = 1'b0;
    unique case (n)
      2'd1: begin
        ok   = is_cont(fl);
        r.cp = {10'd0, lead[4:0], fl[5:0]};
      end
      2'd2: begin
        ok   = is_cont(f0) && is_cont(fl);
        r.cp = {5'd0, lead[3:0], f0[5:0], fl[5:0]};
      end
      default: begin
        ok   = is_cont(f0) && is_cont(f1) && is_cont(fl);
        r.cp = {lead[2:0], f0[5:0], f1[5:0], fl[5:0]};
      end
    endcase
    if (!ok) r = subst();
    return r;
  endfunction

endpackage

@@ hdl/u8d_front.sv @@
module u8d_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            end_of_text,
  output u8d_pkg::push_t  push
);
  import u8d_pkg::*;

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] f0_r, f0_nxt;
  logic [7:0] f1_r, f1_nxt;
  logic [1:0] needed_r, needed_nxt;
  logic [1:0] held_r, held_nxt;
  logic [1:0] n;
  logic [1:0] h;
  job_t       job;

  always_comb begin
    lead_nxt   = lead_r;
    f0_nxt     = f0_r;
    f1_nxt     = f1_r;
    needed_nxt = needed_r;
    held_nxt   = held_r;
    n          = lead_len(data_byte);
    h          = held_r + 2'd1;
    job        = '0;
    job.last   = end_of_text;

    if (needed_r == 2'd0) begin
      if (!data_byte[7]) begin
        job.cnt    = 2'd1;
        job.res[0] = single(data_byte);
      end else if (n != 2'd0 && !end_of_text) begin
        lead_nxt   = data_byte;
        needed_nxt = n;
        held_nxt   = 2'd0;
      end else begin
        job.cnt    = 2'd1;
        job.res[0] = subst();
      end
    end else begin
      if (held_r == 2'd0) f0_nxt = data_byte;
      if (held_r == 2'd1) f1_nxt = data_byte;
      if (h >= needed_r) begin
        job.cnt    = 2'd1;
        job.res[0] = assemble(lead_r, f0_r, f1_r, data_byte, needed_r);
        needed_nxt = 2'd0;
        held_nxt   = 2'd0;
      end else if (end_of_text) begin
        // open lead is bad, then re-decode what was held
        job.res[0] = subst();
        if (h == 2'd1) begin
          job.cnt    = 2'd2;
          job.res[1] = single(data_byte);
        end else if (!f0_r[7]) begin
          job.cnt    = 2'd3;
          job.res[1] = single(f0_r);
          job.res[2] = single(data_byte);
        end else if (lead_len(f0_r) == 2'd1) begin
          job.cnt    = 2'd2;
          job.res[1] = assemble(f0_r, f0_r, f0_r, data_byte, 2'd1);
        end else begin
          job.cnt    = 2'd3;
          job.res[1] = subst();
          job.res[2] = single(data_byte);
        end
      end else begin
        held_nxt = h;
      end
    end

    if (end_of_text) begin
      needed_nxt = 2'd0;
      held_nxt   = 2'd0;
    end
  end

  assign push.valid = accept && (job.cnt != 2'd0);
  assign push.job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= '0;
      needed_r <= '0;
      held_r   <= '0;
    end else if (accept) begin
      lead_r   <= lead_nxt;
      needed_r <= needed_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f0_r <= f0_nxt;
      f1_r <= f1_nxt;
    end
  end

endmodule

@@ hdl/u8d_queue.sv @@
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  u8d_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output u8d_pkg::job_t  head
);
  import u8d_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push.job;
  end

endmodule

@@ hdl/u8d_back.sv @@
module u8d_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  u8d_pkg::job_t                 head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u8d_pkg::CP_W-1:0]      out_code_point,
  output logic                          out_is_replacement,
  output logic                          out_last_of_text
);
  import u8d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       final_res;
  result_t    cur;

  assign cur       = head.res[idx_r];
  assign final_res = (idx_r == head.cnt - 2'd1);

  assign out_valid          = head_valid;
  assign out_code_point     = cur.cp;
  assign out_is_replacement = cur.rep;
  assign out_last_of_text   = head.last && final_res;
  assign pop                = out_valid && out_ready && final_res;

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) idx_nxt = final_res ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else idx_r <= idx_nxt;
  end

endmodule

@@ hdl/utf8_codepoint_decoder.sv @@
// channel  | ports                                        | direction
// ---------+----------------------------------------------+----------
// input    | in_valid, in_ready, in_data_byte,            | in
//          | in_end_of_text                               |
// result   | out_valid, out_ready, out_code_point,        | out
//          | out_is_replacement, out_last_of_text         |
//
// one byte word accepted per cycle while the job queue has room
// a byte yields 0 to 3 result words, sent one per cycle from the queue head while out_ready is high
// byte to first result: combinational front decode, then the queue register
// synchronous active-low reset empties the queue and closes any open sequence
// a stalled result side backs up into the queue, then drops in_ready
module utf8_codepoint_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_end_of_text,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [u8d_pkg::CP_W-1:0] out_code_point,
  output logic                     out_is_replacement,
  output logic                     out_last_of_text
);
  import u8d_pkg::*;

  push_t push;
  job_t  head;
  logic  full;
  logic  head_valid;
  logic  pop;
  logic  accept;

  // front takes a word whenever the queue has a free slot
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // front: sequence state and per-byte result list
  u8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .end_of_text(in_end_of_text),
    .push       (push)
  );

  // short job queue decoupling both sides
  u8d_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  // back: walks the results of the head job
  u8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_is_replacement(out_is_replacement),
    .out_last_of_text  (out_last_of_text)
  );

endmodule

@@ hdl/u8d_checker.sv @@
module u8d_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [u8d_pkg::CP_W-1:0] out_code_point,
  input logic                     out_is_replacement,
  input logic                     out_last_of_text
);
  import u8d_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
      && $stable(out_is_replacement) && $stable(out_last_of_text))
    else $error("result word changed while stalled");

  a_rep_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_replacement |-> out_code_point == SUBST_CP)
    else $error("replacement flag without substitute code point");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind utf8_codepoint_decoder u8d_checker u_chk (.*);

@@ bench/utf8_codepoint_decoder_test.sv @@
`timescale 1ns / 1ps

module utf8_codepoint_decoder_test;

  localparam int unsigned CPW = u8d_pkg::CP_W;

  // one byte word of encoded text as offered on the input side
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_byte_t;

  // one decoded word as it should leave the result side
  typedef struct packed {
    logic [CPW-1:0] cp;
    logic           rep;
    logic           last;
  } cp_word_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     in_data_byte = 8'h00;
  logic           in_end_of_text = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CPW-1:0] out_code_point;
  logic           out_is_replacement;
  logic           out_last_of_text;

  utf8_codepoint_decoder uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_point     (out_code_point),
    .out_is_replacement (out_is_replacement),
    .out_last_of_text   (out_last_of_text)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // text waiting to be offered, and decoded words still owed by the block
  text_byte_t bytes_pending[$];
  cp_word_t   cp_words_due[$];

  int fails = 0;
  int bytes_taken = 0;
  logic hold_off = 1'b0;

  // ---------------------------------------------------------------------------
  // decoder prediction: own copy of the open sequence
  // ---------------------------------------------------------------------------
  logic [7:0]  seq_lead = 8'h00;
  logic [7:0]  seq_foll[3] = '{8'h00, 8'h00, 8'h00};
  int unsigned seq_need = 0;
  int unsigned seq_have = 0;

  // words produced by one byte, at most three
  cp_word_t    step_words[3];
  int unsigned step_count;

  // followers a lead byte asks for, 0 for anything that is not a lead
  function automatic int unsigned follower_count(input logic [7:0] c);
    int unsigned n;
    casez (c)
      8'b110?_????: n = 1;
      8'b1110_????: n = 2;
      8'b1111_0???: n = 3;
      default:      n = 0;
    endcase
    return n;
  endfunction

  task automatic add_word(input logic [CPW-1:0] cp, input logic rep);
    step_words[step_count].cp   = cp;
    step_words[step_count].rep  = rep;
    step_words[step_count].last = 1'b0;
    step_count++;
  endtask

  task automatic add_substitute();
    add_word(u8d_pkg::SUBST_CP, 1'b1);
  endtask

  // lead plus n followers: the code point, or the substitute on a bad follower
  task automatic add_sequence(input logic [7:0] lead, input int unsigned n,
                              input logic [7:0] f0, input logic [7:0] f1,
                              input logic [7:0] f2);
    logic [7:0]     fl[3];
    logic [CPW-1:0] value;
    logic           good;
    fl[0] = f0;
    fl[1] = f1;
    fl[2] = f2;
    good  = 1'b1;
    // payload bits of the lead shrink as the sequence grows
    value = CPW'(lead & (8'h3F >> n));
    for (int i = 0; i < int'(n); i++) begin
      if (fl[i][7:6] != 2'b10) good = 1'b0;
      value = (value << 6) | CPW'(fl[i][5:0]);
    end
    if (good) add_word(value, 1'b0);
    else add_substitute();
  endtask

  // followers held when the text stops early, decoded afresh as a tail
  task automatic add_tail(input int unsigned k);
    logic [7:0]  t[5];
    logic [7:0]  c;
    int unsigned i;
    int unsigned n;
    t[0] = seq_foll[0];
    t[1] = seq_foll[1];
    t[2] = 8'h00;
    t[3] = 8'h00;
    t[4] = 8'h00;
    i = 0;
    while (i < k) begin
      c = t[i];
      i++;
      n = follower_count(c);
      if (!c[7]) begin
        add_word(CPW'(c), 1'b0);
      end else if (n > 0 && i + n <= k) begin
        add_sequence(c, n, t[i], t[i+1], t[i+2]);
        i += n;
      end else begin
        add_substitute();
      end
    end
  endtask

  // one accepted byte word in, the words it releases appended to the due list
  task automatic predict_byte(input logic [7:0] b, input logic eot);
    int unsigned n;
    step_count = 0;
    if (seq_need == 0) begin
      n = follower_count(b);
      if (!b[7]) begin
        add_word(CPW'(b), 1'b0);
      end else if (n > 0 && !eot) begin
        seq_lead = b;
        seq_need = n;
        seq_have = 0;
      end else begin
        // stray follower, bad lead, or a lead that ends the text
        add_substitute();
      end
    end else begin
      seq_foll[seq_have] = b;
      seq_have++;
      if (seq_have >= seq_need) begin
        add_sequence(seq_lead, seq_need, seq_foll[0], seq_foll[1], seq_foll[2]);
        seq_need = 0;
        seq_have = 0;
      end else if (eot) begin
        // text cut inside a sequence: lead is lost, held followers re-read
        add_substitute();
        add_tail(seq_have);
        seq_need = 0;
        seq_have = 0;
      end
    end
    if (eot) begin
      seq_need = 0;
      seq_have = 0;
      if (step_count > 0) step_words[step_count-1].last = 1'b1;
    end
    for (int i = 0; i < int'(step_count); i++) cp_words_due = {cp_words_due, step_words[i]};
  endtask

  // ---------------------------------------------------------------------------
  // gap choice shared by both sides: mostly none, some short, few long,
  // and now and then a calm stretch with no gaps at all
  // ---------------------------------------------------------------------------
  task automatic draw_gap(inout int calm, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (r < 3) begin
      calm = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, predicts each one the edge it is taken
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  int in_calm = 0;
  text_byte_t next_byte;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_byte(in_data_byte, in_end_of_text);
        bytes_taken++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (bytes_pending.size() > 0) begin
        next_byte = bytes_pending.pop_front();
        in_data_byte   <= next_byte.data;
        in_end_of_text <= next_byte.eot;
        in_valid       <= 1'b1;
        draw_gap(in_calm, in_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every taken word against the oldest one due
  // ---------------------------------------------------------------------------
  int out_gap = 0;
  int out_calm = 0;
  cp_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cp_words_due.size() == 0) begin
          $error("word with none due: code_point %h", out_code_point);
          fails++;
        end else begin
          want = cp_words_due.pop_front();
          if (out_code_point !== want.cp) begin
            $error("code_point: expected %h, got %h", want.cp, out_code_point);
            fails++;
          end
          if (out_is_replacement !== want.rep) begin
            $error("is_replacement: expected %b, got %b", want.rep, out_is_replacement);
            fails++;
          end
          if (out_last_of_text !== want.last) begin
            $error("last_of_text: expected %b, got %b", want.last, out_last_of_text);
            fails++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !hold_off;
        draw_gap(out_calm, out_gap);
      end
    end
  end

  // long receiver stall while the sender keeps offering, so input backs up
  initial begin
    while (bytes_taken < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t.data = b;
    t.eot  = eot;
    bytes_pending = {bytes_pending, t};
  endtask

  function automatic logic [7:0] rand_follower();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // one random text: mostly well-formed symbols, some broken or cut short
  task automatic queue_text(output int queued);
    logic [7:0] txt[$];
    logic [7:0] lead_b;
    int         symbols;
    int         kind;
    int         n;
    int         bad;
    int         cut;
    logic       eot;
    symbols = $urandom_range(1, 8);
    for (int s = 0; s < symbols; s++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: txt = {txt, 8'($urandom_range(0, 127))};
        3, 4: begin
          txt = {txt, {3'b110, 5'($urandom_range(0, 31))}};
          txt = {txt, rand_follower()};
        end
        5, 6: begin
          txt = {txt, {4'b1110, 4'($urandom_range(0, 15))}};
          repeat (2) txt = {txt, rand_follower()};
        end
        7: begin
          txt = {txt, {5'b11110, 3'($urandom_range(0, 7))}};
          repeat (3) txt = {txt, rand_follower()};
        end
        8: begin
          // sequence with one follower replaced by a random byte, which may break the pattern
          n   = $urandom_range(1, 3);
          bad = $urandom_range(0, n - 1);
          lead_b = (8'hFF << (7 - n)) | 8'($urandom_range(0, 255) >> (n + 2));
          txt = {txt, lead_b};
          for (int i = 0; i < n; i++) begin
            if (i == bad) txt = {txt, 8'($urandom_range(0, 255))};
            else txt = {txt, rand_follower()};
          end
        end
        default: txt = {txt, 8'($urandom_range(0, 255))};
      endcase
    end
    // sometimes the text is cut short, possibly mid-symbol
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, txt.size());
      while (txt.size() > cut) void'(txt.pop_back());
    end
    eot = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < txt.size(); i++) queue_byte(txt[i], eot && (i == txt.size() - 1));
    queued = txt.size();
  endtask

  int random_bytes;
  int got;

  initial begin
    // ascii extremes
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    // two, three and four byte code points, the last one the largest value
    queue_byte(8'hC2, 1'b0); queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF7, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    // follower that is not of the 10xxxxxx form, still consumed
    queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b0);
    // stray follower and bytes that never lead
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF8, 1'b0);
    // text ends on a lead byte
    queue_byte(8'hC2, 1'b1);
    // text ends inside a four byte sequence, held pair decodes as a code point
    queue_byte(8'hF0, 1'b0); queue_byte(8'hC2, 1'b0); queue_byte(8'hA9, 1'b1);
    // text ends inside a three byte sequence, held byte is plain ascii
    queue_byte(8'hE1, 1'b0); queue_byte(8'h41, 1'b1);
    // text ends inside, held byte a lead with no room: three substitutes
    queue_byte(8'hF4, 1'b0); queue_byte(8'hE0, 1'b0); queue_byte(8'hC3, 1'b1);
    // ascii that ends a text
    queue_byte(8'h7F, 1'b1);

    random_bytes = 0;
    while (random_bytes < 170) begin
      queue_text(got);
      random_bytes += got;
    end
    queue_byte(8'h2E, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (bytes_pending.size() != 0 || in_valid || cp_words_due.size() != 0);
    repeat (20) @(posedge clk);

    if (fails == 0) begin
      $display("[utf8_codepoint_decoder] OK");
    end else begin
      $display("[utf8_codepoint_decoder] ERROR");
    end
    $finish;
  end

  // run limit, well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("[utf8_codepoint_decoder] ERROR");
    $finish;
  end

endmodule

@@ utf8_codepoint_decoder.f @@
hdl/u8d_pkg.sv
hdl/u8d_front.sv
hdl/u8d_queue.sv
hdl/u8d_back.sv
hdl/utf8_codepoint_decoder.sv
hdl/u8d_checker.sv
bench/utf8_codepoint_decoder_test.sv
